// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by msp_frame_receiver.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mspfr_pkg.sv =====
// Types, constants and the CRC-8 DVB-S2 step for the MSP frame receiver.
// No dependencies.
package mspfr_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES = 256;
    localparam int unsigned OFS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int unsigned HDR_DEPTH = 7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_HASH   = 8'h23;

    localparam logic [7:0] CMD_TUNNEL     = 8'hFF;
    localparam logic [7:0] TUNNEL_MIN_LEN = 8'd6;
    localparam logic [7:0] CRC_POLY       = 8'hD5;
    localparam logic [7:0] REBOOT_CHAR_RST = 8'd82;

    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_START   = 4'd1,
        S_GOT_M   = 4'd2,
        S_GOT_X   = 4'd3,
        S_HDR_V1  = 4'd4,
        S_PAY_V1  = 4'd5,
        S_CK_V1   = 4'd6,
        S_HDR_TUN = 4'd7,
        S_PAY_TUN = 4'd8,
        S_CK_TUN  = 4'd9,
        S_HDR_V2  = 4'd10,
        S_PAY_V2  = 4'd11,
        S_CK_V2   = 4'd12
    } t_state;

    typedef enum logic [1:0] {
        VER_V1  = 2'd0,
        VER_TUN = 2'd1,
        VER_V2  = 2'd2
    } t_version;

    typedef enum logic [1:0] {
        STAT_NONE    = 2'd0,
        STAT_GOOD    = 2'd1,
        STAT_BAD_CK  = 2'd2,
        STAT_ABANDON = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_CLI    = 2'd1,
        REQ_REBOOT = 2'd2
    } t_request;

    typedef enum logic {
        CFG_DETECT_NON_MSP = 1'b0,
        CFG_REBOOT_CHAR    = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic        consumed;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        t_status     frame_status;
        logic [1:0]  frame_version;
        logic [15:0] command_code;
        logic [7:0]  frame_flags;
        logic [8:0]  payload_length;
        t_request    special_request;
    } t_result;

    function automatic logic [7:0] crc8_d5_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/msp_frame_receiver.sv =====
// Top level of the MSP frame receiver: input register, config registers, result register.
// Depends on mspfr_pkg, mspfr_parser and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  rx      | in        | i_in_valid / o_in_stall | i_rx_byte
//  result  | out       | o_out_valid / i_out_stall | o_consumed .. o_special_request
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the result is not stalled; a byte passes the input
// register, then parser logic into the result register.
// Reset is synchronous, active low; the parser returns to idle.
// A stalled result holds; the input stage stalls only while both stages are full
// and the result is stalled.
`include "assert_macros.svh"

module msp_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_consumed,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [1:0]  o_frame_status,
    output logic [1:0]  o_frame_version,
    output logic [15:0] o_command_code,
    output logic [7:0]  o_frame_flags,
    output logic [8:0]  o_payload_length,
    output logic [1:0]  o_special_request,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import mspfr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_detect_non_msp;
    logic [7:0] r_reboot_char;

    logic       w_out_free;
    logic       w_advance;
    t_result    w_result;
    t_cfg_reg   w_cfg_reg;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_reg  = t_cfg_reg'(i_cfg_index);

    mspfr_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_rx_byte        (r_in_byte),
        .i_detect_non_msp (r_detect_non_msp),
        .i_reboot_char    (r_reboot_char),
        .o_result         (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_non_msp <= 1'b0;
            r_reboot_char    <= REBOOT_CHAR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (w_cfg_reg)
                CFG_DETECT_NON_MSP: r_detect_non_msp <= i_cfg_data[0];
                CFG_REBOOT_CHAR:    r_reboot_char    <= i_cfg_data;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_consumed        = r_out.consumed;
    assign o_payload_valid   = r_out.payload_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_payload_index   = r_out.payload_index;
    assign o_frame_status    = r_out.frame_status;
    assign o_frame_version   = r_out.frame_version;
    assign o_command_code    = r_out.command_code;
    assign o_frame_flags     = r_out.frame_flags;
    assign o_payload_length  = r_out.payload_length;
    assign o_special_request = r_out.special_request;

    `ASSERT_IMPLIES(a_pay_consumed, i_clk, i_rst_n, o_out_valid && o_payload_valid, o_consumed && o_frame_status == STAT_NONE, "payload byte not consumed or ends a frame")
    `ASSERT_IMPLIES(a_req_unconsumed, i_clk, i_rst_n, o_out_valid && o_special_request != REQ_NONE, !o_consumed && o_frame_status == STAT_NONE, "request raised on a parsed byte")
    `ASSERT_IMPLIES(a_status_consumed, i_clk, i_rst_n, o_out_valid && o_frame_status != STAT_NONE, o_consumed && !o_payload_valid, "frame end on an unparsed byte")
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_out_free, r_in_valid && $stable(r_in_byte), "held input byte lost")

endmodule

// ===== hw/rtl/mspfr_parser.sv =====
// MSP frame parser: state, header capture, XOR and CRC sums, per-byte result.
// Depends on mspfr_pkg.
module mspfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_detect_non_msp,
    input  logic [7:0]          i_reboot_char,
    output mspfr_pkg::t_result  o_result
);
    import mspfr_pkg::*;

    t_state                 r_state, n_state;
    logic [OFS_W-1:0]       r_offset, n_offset;
    logic [7:0]             r_xor, n_xor;
    logic [7:0]             r_crc, n_crc;
    t_version               r_version, n_version;
    logic [OFS_W-1:0]       r_size, n_size;
    logic [15:0]            r_command, n_command;
    logic [7:0]             r_flags, n_flags;
    logic [7:0]             r_hdr [HDR_DEPTH];

    logic                   w_hdr_we;
    logic [2:0]             w_hdr_idx;
    logic [7:0]             w_crc_step;
    logic [OFS_W-1:0]       w_ofs_inc;
    logic [15:0]            w_ofs16;
    logic [15:0]            w_size16;
    logic [15:0]            w_v2_size;
    logic [15:0]            w_tun_size;

    assign w_crc_step = crc8_d5_update(r_crc, i_rx_byte);
    assign w_ofs_inc  = r_offset + OFS_W'(1);
    assign w_ofs16    = 16'(r_offset);
    assign w_size16   = 16'(r_size);
    assign w_hdr_idx  = w_ofs16[2:0];
    assign w_v2_size  = {i_rx_byte, r_hdr[3]};
    assign w_tun_size = {i_rx_byte, r_hdr[5]};

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_offset  = r_offset;
        n_xor     = r_xor;
        n_crc     = r_crc;
        n_version = r_version;
        n_size    = r_size;
        n_command = r_command;
        n_flags   = r_flags;
        w_hdr_we  = 1'b0;
        unique case (r_state)
            S_START: begin
                if (i_rx_byte == CH_M) begin
                    n_state = S_GOT_M;
                end else if (i_rx_byte == CH_X) begin
                    n_state = S_GOT_X;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_GOT_M: begin
                n_state = S_IDLE;
                if (i_rx_byte == CH_LT) begin
                    n_offset = '0;
                    n_xor    = '0;
                    n_crc    = '0;
                    n_state  = S_HDR_V1;
                end
            end
            S_GOT_X: begin
                n_state = S_IDLE;
                if (i_rx_byte == CH_LT) begin
                    n_offset  = '0;
                    n_crc     = '0;
                    n_version = VER_V2;
                    n_state   = S_HDR_V2;
                end
            end
            S_HDR_V1: begin
                w_hdr_we = (w_ofs16 < 16'(HDR_DEPTH));
                n_offset = w_ofs_inc;
                n_xor    = r_xor ^ i_rx_byte;
                if (w_ofs16 == 16'd1) begin
                    if (16'(r_hdr[0]) > 16'(MAX_PAYLOAD_BYTES)) begin
                        n_state = S_IDLE;
                    end else if (i_rx_byte == CMD_TUNNEL) begin
                        if (r_hdr[0] >= TUNNEL_MIN_LEN) begin
                            n_version = VER_TUN;
                            n_state   = S_HDR_TUN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_size    = OFS_W'(r_hdr[0]);
                        n_command = 16'(i_rx_byte);
                        n_flags   = '0;
                        n_offset  = '0;
                        n_state   = (r_hdr[0] != 8'd0) ? S_PAY_V1 : S_CK_V1;
                    end
                end
            end
            S_HDR_TUN: begin
                w_hdr_we = (w_ofs16 < 16'(HDR_DEPTH));
                n_offset = w_ofs_inc;
                n_xor    = r_xor ^ i_rx_byte;
                n_crc    = w_crc_step;
                if (w_ofs16 == 16'd6) begin
                    if (w_tun_size > 16'(MAX_PAYLOAD_BYTES)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_size    = OFS_W'(w_tun_size);
                        n_flags   = r_hdr[2];
                        n_command = {r_hdr[4], r_hdr[3]};
                        n_offset  = '0;
                        n_state   = (w_tun_size != 16'd0) ? S_PAY_TUN : S_CK_TUN;
                    end
                end
            end
            S_HDR_V2: begin
                w_hdr_we = (w_ofs16 < 16'(HDR_DEPTH));
                n_offset = w_ofs_inc;
                n_crc    = w_crc_step;
                if (w_ofs16 == 16'd4) begin
                    if (w_v2_size > 16'(MAX_PAYLOAD_BYTES)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_size    = OFS_W'(w_v2_size);
                        n_flags   = r_hdr[0];
                        n_command = {r_hdr[2], r_hdr[1]};
                        n_offset  = '0;
                        n_state   = (w_v2_size != 16'd0) ? S_PAY_V2 : S_CK_V2;
                    end
                end
            end
            S_PAY_V1: begin
                n_xor    = r_xor ^ i_rx_byte;
                n_offset = w_ofs_inc;
                if (w_ofs_inc == r_size) begin
                    n_state = S_CK_V1;
                end
            end
            S_PAY_TUN: begin
                n_xor    = r_xor ^ i_rx_byte;
                n_crc    = w_crc_step;
                n_offset = w_ofs_inc;
                if (w_ofs_inc == r_size) begin
                    n_state = S_CK_TUN;
                end
            end
            S_PAY_V2: begin
                n_crc    = w_crc_step;
                n_offset = w_ofs_inc;
                if (w_ofs_inc == r_size) begin
                    n_state = S_CK_V2;
                end
            end
            S_CK_TUN: begin
                n_xor   = r_xor ^ i_rx_byte;
                n_state = (r_crc == i_rx_byte) ? S_CK_V1 : S_IDLE;
            end
            S_CK_V1, S_CK_V2: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                if (i_rx_byte == CH_DOLLAR) begin
                    n_version = VER_V1;
                    n_state   = S_START;
                end
            end
        endcase
    end

    // per-byte result
    always_comb begin
        o_result                 = '0;
        o_result.consumed        = 1'b1;
        o_result.frame_status    = STAT_NONE;
        o_result.special_request = REQ_NONE;
        unique case (r_state)
            S_START, S_GOT_M, S_GOT_X: begin
            end
            S_HDR_V1: begin
                if (w_ofs16 == 16'd1) begin
                    if (16'(r_hdr[0]) > 16'(MAX_PAYLOAD_BYTES)) begin
                        o_result.frame_status = STAT_ABANDON;
                    end else if (i_rx_byte == CMD_TUNNEL && r_hdr[0] < TUNNEL_MIN_LEN) begin
                        o_result.frame_status = STAT_ABANDON;
                    end
                end
            end
            S_HDR_TUN: begin
                if (w_ofs16 == 16'd6 && w_tun_size > 16'(MAX_PAYLOAD_BYTES)) begin
                    o_result.frame_status = STAT_ABANDON;
                end
            end
            S_HDR_V2: begin
                if (w_ofs16 == 16'd4 && w_v2_size > 16'(MAX_PAYLOAD_BYTES)) begin
                    o_result.frame_status = STAT_ABANDON;
                end
            end
            S_PAY_V1, S_PAY_TUN, S_PAY_V2: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_rx_byte;
                o_result.payload_index = w_ofs16[7:0];
            end
            S_CK_TUN: begin
                if (r_crc != i_rx_byte) begin
                    o_result.frame_status = STAT_BAD_CK;
                end
            end
            S_CK_V1: begin
                o_result.frame_status = (r_xor == i_rx_byte) ? STAT_GOOD : STAT_BAD_CK;
            end
            S_CK_V2: begin
                o_result.frame_status = (r_crc == i_rx_byte) ? STAT_GOOD : STAT_BAD_CK;
            end
            default: begin
                if (i_rx_byte != CH_DOLLAR) begin
                    o_result.consumed = 1'b0;
                    if (i_detect_non_msp) begin
                        if (i_rx_byte == CH_HASH) begin
                            o_result.special_request = REQ_CLI;
                        end else if (i_rx_byte == i_reboot_char) begin
                            o_result.special_request = REQ_REBOOT;
                        end
                    end
                end
            end
        endcase
        if (o_result.frame_status != STAT_NONE) begin
            o_result.frame_version = r_version;
        end
        if (o_result.frame_status == STAT_GOOD || o_result.frame_status == STAT_BAD_CK) begin
            o_result.command_code   = r_command;
            o_result.frame_flags    = r_flags;
            o_result.payload_length = w_size16[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_offset  <= '0;
            r_xor     <= '0;
            r_crc     <= '0;
            r_version <= VER_V1;
            r_size    <= '0;
            r_command <= '0;
            r_flags   <= '0;
        end else if (i_advance) begin
            r_state   <= n_state;
            r_offset  <= n_offset;
            r_xor     <= n_xor;
            r_crc     <= n_crc;
            r_version <= n_version;
            r_size    <= n_size;
            r_command <= n_command;
            r_flags   <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_hdr_we) begin
            r_hdr[w_hdr_idx] <= i_rx_byte;
        end
    end

endmodule
